// ===== hdl/pidc_pkg.sv =====
// Shared types, codes and widths for the dual-form PID controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int DataW   = 32;
  localparam int GainW   = 31;
  localparam int ModeW   = 3;
  localparam int CfgIdxW = 3;
  localparam int LoopW   = 25;  // loop time is below 2^25
  localparam int ScaleAW = 36;  // signed operand of the scaling unit
  localparam int ScaleBW = 56;  // unsigned factor, wide enough for ki*T
  localparam int ProdW   = ScaleAW + ScaleBW;
  localparam int DenW    = 33;
  localparam int SumW    = 34;

  localparam logic [ModeW-1:0] MODE_HEAT_STD = 3'd0;
  localparam logic [ModeW-1:0] MODE_HEAT_PAR = 3'd1;
  localparam logic [ModeW-1:0] MODE_HEAT_MAN = 3'd2;
  localparam logic [ModeW-1:0] MODE_COOL_STD = 3'd3;
  localparam logic [ModeW-1:0] MODE_COOL_PAR = 3'd4;
  localparam logic [ModeW-1:0] MODE_COOL_MAN = 3'd5;

  localparam logic [ModeW-1:0]        ModeRst  = MODE_HEAT_MAN;
  localparam logic [GainW-1:0]        KpRst    = 31'd65536;
  localparam logic signed [DataW-1:0] LimitRst = 32'sd6553600;

  typedef struct packed {
    logic signed [DataW-1:0] measurement;
    logic signed [DataW-1:0] target;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    in_window;
    logic                    at_limit;
  } out_item_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE      = 3'd0,
    CFG_KP        = 3'd1,
    CFG_KI        = 3'd2,
    CFG_KD        = 3'd3,
    CFG_INT_MAX   = 3'd4,
    CFG_INT_MIN   = 3'd5,
    CFG_DRIVE_MAX = 3'd6,
    CFG_DRIVE_MIN = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FORM_MAN,
    FORM_STD,
    FORM_PAR
  } form_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_P,
    OP_ITERM_STD,
    OP_DTERM_STD,
    OP_INC_STD,
    OP_KT,
    OP_IVAL_PAR,
    OP_DTERM_PAR
  } op_e;

  typedef enum logic [1:0] {
    DK_RAW,
    DK_SH16,
    DK_SH17,
    DK_DIV
  } dk_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_POST,
    SC_DIV
  } sc_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PLAN,
    ST_START,
    ST_WAIT,
    ST_FIN,
    ST_STORE
  } ctrl_state_e;

  typedef struct packed {
    logic  capture;
    logic  eval;
    logic  start;
    logic  finish;
    logic  store;
    logic  cool;
    form_e form;
    op_e   op;
  } cmd_t;

  typedef struct packed {
    logic sc_done;
    logic win;
    logic ki_zero;
  } status_t;

endpackage

// ===== hdl/pidc_scale.sv =====
// Scaling unit: a*b raw, or trunc(a*b/d) saturated to 32 bits, d shift/div.
// Radix-256 multiplier followed by a restoring divider; uses pidc_pkg.
`timescale 1ns / 1ps

module pidc_scale
  import pidc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [ScaleAW-1:0]  a_i,
  input  logic        [ScaleBW-1:0]  b_i,
  input  dk_e                        dk_i,
  input  logic        [DenW-1:0]     den_i,
  output logic                       done_o,
  output logic signed [DataW-1:0]    term_o,
  output logic        [ScaleBW-1:0]  raw_o
);

  localparam int DigW   = 8;
  localparam int Digits = ScaleBW / DigW;
  localparam int QuoW   = DataW - 1;
  localparam int DshW   = DenW + QuoW - 1;
  localparam int CntW   = $clog2(QuoW);

  localparam logic [DataW-1:0] Cap    = {1'b1, {QuoW{1'b0}}};
  localparam logic [DataW-1:0] PosMax = {1'b0, {QuoW{1'b1}}};

  sc_state_e               st_q, st_d;
  logic                    neg_q, neg_d;
  dk_e                     dk_q, dk_d;
  logic [DenW-1:0]         den_q, den_d;
  logic [ScaleAW-1:0]      mag_q, mag_d;
  logic [ScaleBW-1:0]      mb_q, mb_d;
  logic [ProdW-1:0]        prod_q, prod_d;
  logic [DshW-1:0]         dsh_q, dsh_d;
  logic [QuoW-1:0]         quo_q, quo_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic signed [DataW-1:0] term_q, term_d;
  logic [ScaleBW-1:0]      raw_q, raw_d;
  logic                    done_q, done_d;

  logic [ScaleAW-1:0]      a_mag;
  logic [ScaleAW+DigW-1:0] partial;
  logic [ProdW-1:0]        sh;
  logic [ProdW-1:0]        dsh_x;
  logic                    ge;
  logic [QuoW-1:0]         quo_n;
  logic                    fin;
  logic [DataW-1:0]        fin_mag;

  assign a_mag   = a_i[ScaleAW-1] ? ScaleAW'(-a_i) : ScaleAW'(a_i);
  assign partial = mag_q * mb_q[ScaleBW-1 -: DigW];
  assign sh      = (dk_q == DK_SH17) ? (prod_q >> 17) : (prod_q >> 16);
  assign dsh_x   = ProdW'(dsh_q);
  assign ge      = prod_q >= dsh_x;
  assign quo_n   = {quo_q[QuoW-2:0], ge};

  always_comb begin
    st_d    = st_q;
    neg_d   = neg_q;
    dk_d    = dk_q;
    den_d   = den_q;
    mag_d   = mag_q;
    mb_d    = mb_q;
    prod_d  = prod_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    raw_d   = raw_q;
    fin     = 1'b0;
    fin_mag = '0;
    case (st_q)
      SC_IDLE: begin
        if (start_i) begin
          neg_d  = a_i[ScaleAW-1];
          mag_d  = a_mag;
          mb_d   = b_i;
          dk_d   = dk_i;
          den_d  = den_i;
          prod_d = '0;
          cnt_d  = CntW'(Digits - 1);
          st_d   = SC_MUL;
        end
      end
      SC_MUL: begin
        // Horner over the factor, top digit first
        prod_d = {prod_q[ProdW-DigW-1:0], {DigW{1'b0}}} + ProdW'(partial);
        mb_d   = {mb_q[ScaleBW-DigW-1:0], {DigW{1'b0}}};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          st_d = SC_POST;
        end
      end
      SC_POST: begin
        case (dk_q)
          DK_RAW: begin
            raw_d = prod_q[ScaleBW-1:0];
            fin   = 1'b1;
          end
          DK_SH16, DK_SH17: begin
            fin     = 1'b1;
            fin_mag = (sh[ProdW-1:QuoW] != '0) ? Cap : {1'b0, sh[QuoW-1:0]};
          end
          default: begin
            // quotient of 2^31 or more only saturates
            if (prod_q >= ProdW'({den_q, {QuoW{1'b0}}})) begin
              fin     = 1'b1;
              fin_mag = Cap;
            end else begin
              dsh_d = {den_q, {(QuoW-1){1'b0}}};
              quo_d = '0;
              cnt_d = CntW'(QuoW - 1);
              st_d  = SC_DIV;
            end
          end
        endcase
      end
      SC_DIV: begin
        if (ge) begin
          prod_d = prod_q - dsh_x;
        end
        quo_d = quo_n;
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          fin     = 1'b1;
          fin_mag = {1'b0, quo_n};
        end
      end
      default: st_d = SC_IDLE;
    endcase
    if (fin) begin
      st_d = SC_IDLE;
    end
    done_d = fin;
    if (neg_q) begin
      term_d = -$signed(fin_mag);
    end else begin
      term_d = fin_mag[DataW-1] ? $signed(PosMax) : $signed(fin_mag);
    end
    if (!fin || dk_q == DK_RAW) begin
      term_d = term_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SC_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    dk_q   <= dk_d;
    den_q  <= den_d;
    mag_q  <= mag_d;
    mb_q   <= mb_d;
    prod_q <= prod_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    term_q <= term_d;
    raw_q  <= raw_d;
  end

  assign done_o = done_q;
  assign term_o = term_q;
  assign raw_o  = raw_q;

endmodule

// ===== hdl/pidc_dp.sv =====
// Datapath: error and window, controller state, term registers, clamps, result register.
// Instantiates pidc_scale; uses pidc_pkg.
`timescale 1ns / 1ps

module pidc_dp
  import pidc_pkg::*;
#(
  parameter int LOOP_TIME_Q16  = 65536,
  parameter int WINDOW_PERCENT = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  in_item_t                in_item_i,
  input  logic [GainW-1:0]        kp_i,
  input  logic [GainW-1:0]        ki_i,
  input  logic [GainW-1:0]        kd_i,
  input  logic signed [DataW-1:0] int_max_i,
  input  logic signed [DataW-1:0] int_min_i,
  input  logic signed [DataW-1:0] drive_max_i,
  input  logic signed [DataW-1:0] drive_min_i,
  output out_item_t               out_item_o
);

  localparam int WinW = 42;
  localparam logic [LoopW-1:0]     LoopT = LoopW'(LOOP_TIME_Q16);
  localparam logic signed [WinW-1:0] WinC  = WinW'(100);
  localparam logic signed [WinW-1:0] WinHi = WinW'(100 + WINDOW_PERCENT);
  localparam logic signed [WinW-1:0] WinLo = WinW'(100 - WINDOW_PERCENT);

  logic signed [DataW-1:0] m_q, sp_q, e_q, e1_q, e2_q, held_q, isum_q;
  logic signed [DataW-1:0] pterm_q, iterm_q, dterm_q;
  logic                    win_q;
  logic [ScaleBW-1:0]      kt_q;
  logic signed [SumW-1:0]  o_q;
  out_item_t               out_q;

  logic signed [DataW:0]     diff;
  logic signed [DataW-1:0]   err;
  logic signed [WinW-1:0]    m_w, sp_w, lhs, hi, lo;
  logic                      win;
  logic signed [ScaleAW-1:0] e_x, e1_x, e2_x, sc_a;
  logic [ScaleBW-1:0]        sc_b;
  dk_e                       sc_dk;
  logic [DenW-1:0]           sc_den;
  logic                      sc_done;
  logic signed [DataW-1:0]   sc_term;
  logic [ScaleBW-1:0]        sc_raw;
  logic signed [SumW-1:0]    integ_raw, o_std, o_par;
  logic signed [DataW-1:0]   integ_c, drive_c;
  logic                      lim;

  // error, saturated to 32 bits
  assign diff = cmd_i.cool ? ((DataW+1)'(m_q) - (DataW+1)'(sp_q))
                           : ((DataW+1)'(sp_q) - (DataW+1)'(m_q));
  assign err  = (diff[DataW] != diff[DataW-1])
              ? (diff[DataW] ? $signed({1'b1, {(DataW-1){1'b0}}})
                             : $signed({1'b0, {(DataW-1){1'b1}}}))
              : diff[DataW-1:0];

  // exact percent window; a negative setpoint never gives one
  assign m_w  = WinW'(m_q);
  assign sp_w = WinW'(sp_q);
  assign lhs  = m_w * WinC;
  assign hi   = sp_w * WinHi;
  assign lo   = sp_w * WinLo;
  assign win  = (lhs < hi) && (lhs > lo);

  assign e_x  = ScaleAW'(e_q);
  assign e1_x = ScaleAW'(e1_q);
  assign e2_x = ScaleAW'(e2_q);

  always_comb begin
    sc_a   = e_x;
    sc_b   = ScaleBW'(kp_i);
    sc_dk  = DK_SH16;
    sc_den = DenW'(LoopT);
    case (cmd_i.op)
      OP_ITERM_STD: begin
        sc_a   = e_x + e1_x;
        sc_b   = ScaleBW'(LoopT);
        sc_dk  = DK_DIV;
        sc_den = DenW'({ki_i, 1'b0});
      end
      OP_DTERM_STD: begin
        sc_a   = e_x - (e1_x <<< 1) + e2_x;
        sc_b   = ScaleBW'(kd_i);
        sc_dk  = DK_DIV;
      end
      OP_INC_STD: begin
        sc_a = (e_x - e1_x) + ScaleAW'(iterm_q) + ScaleAW'(dterm_q);
      end
      OP_KT: begin
        sc_a  = ScaleAW'($signed({1'b0, ki_i}));
        sc_b  = ScaleBW'(LoopT);
        sc_dk = DK_RAW;
      end
      OP_IVAL_PAR: begin
        sc_a  = e_x + e1_x;
        sc_b  = kt_q;
        sc_dk = DK_SH17;
      end
      OP_DTERM_PAR: begin
        sc_a = e_x - e1_x;
        sc_b = ScaleBW'(kd_i);
      end
      default: ;
    endcase
  end

  pidc_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .a_i     (sc_a),
    .b_i     (sc_b),
    .dk_i    (sc_dk),
    .den_i   (sc_den),
    .done_o  (sc_done),
    .term_o  (sc_term),
    .raw_o   (sc_raw)
  );

  // finish: integrator clamp and drive sum
  assign integ_raw = win_q ? (SumW'(isum_q) + SumW'(iterm_q)) : SumW'(0);
  always_comb begin
    if (integ_raw > SumW'(int_max_i)) begin
      integ_c = int_max_i;
    end else if (integ_raw < SumW'(int_min_i)) begin
      integ_c = int_min_i;
    end else begin
      integ_c = integ_raw[DataW-1:0];
    end
  end
  assign o_std = win_q ? (SumW'(held_q) + SumW'(pterm_q)) : SumW'(pterm_q);
  assign o_par = SumW'(pterm_q) + SumW'(integ_c) + SumW'(dterm_q);

  always_comb begin
    lim = 1'b1;
    if (o_q > SumW'(drive_max_i)) begin
      drive_c = drive_max_i;
    end else if (o_q < SumW'(drive_min_i)) begin
      drive_c = drive_min_i;
    end else begin
      drive_c = o_q[DataW-1:0];
      lim     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      isum_q <= '0;
      e1_q   <= '0;
      e2_q   <= '0;
    end else begin
      if (cmd_i.finish && cmd_i.form == FORM_PAR) begin
        isum_q <= integ_c;
      end
      if (cmd_i.store) begin
        if (cmd_i.form == FORM_MAN) begin
          isum_q <= '0;
          e1_q   <= '0;
        end else begin
          held_q <= drive_c;
          e2_q   <= e1_q;
          e1_q   <= e_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      m_q  <= in_item_i.measurement;
      sp_q <= in_item_i.target;
    end
    if (cmd_i.eval) begin
      e_q     <= err;
      win_q   <= win;
      pterm_q <= '0;
      iterm_q <= '0;
      dterm_q <= '0;
    end
    if (sc_done) begin
      case (cmd_i.op)
        OP_P, OP_INC_STD:            pterm_q <= sc_term;
        OP_ITERM_STD, OP_IVAL_PAR:   iterm_q <= sc_term;
        OP_DTERM_STD, OP_DTERM_PAR:  dterm_q <= sc_term;
        OP_KT:                       kt_q    <= sc_raw;
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      o_q <= (cmd_i.form == FORM_PAR) ? o_par : o_std;
    end
    if (cmd_i.store) begin
      if (cmd_i.form == FORM_MAN) begin
        out_q <= '{drive: held_q, in_window: 1'b0, at_limit: 1'b0};
      end else begin
        out_q <= '{drive: drive_c, in_window: win_q, at_limit: lim};
      end
    end
  end

  assign status_o   = '{sc_done: sc_done, win: win_q, ki_zero: (ki_i == '0)};
  assign out_item_o = out_q;

endmodule

// ===== hdl/pidc_ctrl.sv =====
// Controller: sequences the scaling operations of one item and the handshakes.
// Drives the datapath through cmd_t and reads status_t; uses pidc_pkg.
`timescale 1ns / 1ps

module pidc_ctrl
  import pidc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ModeW-1:0] mode_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  status_t          status_i,
  output cmd_t             cmd_o
);

  ctrl_state_e state_q, state_d;
  op_e         op_q, op_d;
  logic        out_valid_q, out_valid_d;
  form_e       form;
  logic        cool;
  op_e         first_op, nxt_op;

  always_comb begin
    case (mode_i)
      MODE_HEAT_STD, MODE_COOL_STD: form = FORM_STD;
      MODE_HEAT_PAR, MODE_COOL_PAR: form = FORM_PAR;
      default:                      form = FORM_MAN;
    endcase
  end
  assign cool = (mode_i == MODE_COOL_STD) || (mode_i == MODE_COOL_PAR) ||
                (mode_i == MODE_COOL_MAN);

  always_comb begin
    if (form == FORM_STD && status_i.win) begin
      first_op = status_i.ki_zero ? OP_DTERM_STD : OP_ITERM_STD;
    end else begin
      first_op = OP_P;
    end
    case (op_q)
      OP_ITERM_STD: nxt_op = OP_DTERM_STD;
      OP_DTERM_STD: nxt_op = OP_INC_STD;
      OP_P:         nxt_op = (form == FORM_PAR && status_i.win) ? OP_KT : OP_NONE;
      OP_KT:        nxt_op = OP_IVAL_PAR;
      OP_IVAL_PAR:  nxt_op = OP_DTERM_PAR;
      default:      nxt_op = OP_NONE;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.form    = form;
    cmd_o.cool    = cool;
    cmd_o.op      = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = (form == FORM_MAN) ? ST_STORE : ST_PLAN;
      end
      ST_PLAN: begin
        op_d    = first_op;
        state_d = ST_START;
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (status_i.sc_done) begin
          if (nxt_op == OP_NONE) begin
            state_d = ST_FIN;
          end else begin
            op_d    = nxt_op;
            state_d = ST_START;
          end
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_STORE;
      end
      ST_STORE: begin
        // result register must be free or emptying this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.store = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/pid_controller_dual_form.sv =====
// Standard form in the window is the slowest: it runs up to two 31-step divides
// in the scaling unit.
// Throughput: one item at a time; the next is taken while the result waits to be read.
// Each scaling op is a 7-digit multiply plus, for a divisor, 31 restoring divide steps.
// Reset (async, active low) loads register defaults and clears the controller history.
`timescale 1ns / 1ps

module pid_controller_dual_form
  import pidc_pkg::*;
#(
  parameter int LOOP_TIME_Q16  = 65536,
  parameter int WINDOW_PERCENT = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  logic [ModeW-1:0]        mode_q;
  logic [GainW-1:0]        kp_q, ki_q, kd_q;
  logic signed [DataW-1:0] int_max_q, int_min_q, drive_max_q, drive_min_q;
  cmd_t                    cmd;
  status_t                 status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeRst;
      kp_q        <= KpRst;
      ki_q        <= '0;
      kd_q        <= '0;
      int_max_q   <= LimitRst;
      int_min_q   <= '0;
      drive_max_q <= LimitRst;
      drive_min_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:      mode_q      <= cfg_data_i[ModeW-1:0];
        CFG_KP:        kp_q        <= cfg_data_i[GainW-1:0];
        CFG_KI:        ki_q        <= cfg_data_i[GainW-1:0];
        CFG_KD:        kd_q        <= cfg_data_i[GainW-1:0];
        CFG_INT_MAX:   int_max_q   <= cfg_data_i;
        CFG_INT_MIN:   int_min_q   <= cfg_data_i;
        CFG_DRIVE_MAX: drive_max_q <= cfg_data_i;
        CFG_DRIVE_MIN: drive_min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pidc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pidc_dp #(
    .LOOP_TIME_Q16  (LOOP_TIME_Q16),
    .WINDOW_PERCENT (WINDOW_PERCENT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .kp_i        (kp_q),
    .ki_i        (ki_q),
    .kd_i        (kd_q),
    .int_max_i   (int_max_q),
    .int_min_i   (int_min_q),
    .drive_max_i (drive_max_q),
    .drive_min_i (drive_min_q),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== hdl/pidc_checker.sv =====
// Port-level checks for the PID controller, bound to the top level.
// Uses pidc_pkg; tracks items in flight to tie results to inputs.
`timescale 1ns / 1ps

module pidc_assert
  import pidc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_item_i
);

  logic [1:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign pend_d  = pend_q + {1'b0, in_acc} - {1'b0, out_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // one item in work and one result waiting at most
  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items outstanding");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without an item");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("item taken while another is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result dropped or changed while stalled");

endmodule

bind pid_controller_dual_form pidc_assert u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);

// ===== verif/pidc_checker.sv =====
// Watches the sample, result and register channels of the PID controller, predicts each result.
// Compares every result with the oldest prediction. Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_checker
  import pidc_pkg::*;
#(
  parameter int LOOP_TIME_Q16  = 65536,
  parameter int WINDOW_PERCENT = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_item_t           in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_item_t          out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  output int                 pending_o,
  output int                 errors_o
);

  logic [ModeW-1:0]        mode_q;
  logic [GainW-1:0]        kp_q, ki_q, kd_q;
  logic signed [DataW-1:0] imax_q, imin_q, dmax_q, dmin_q;
  logic signed [DataW-1:0] held_q, isum_q, e1_q, e2_q;
  out_item_t               drive_queue[$];
  int                      errors;

  assign pending_o = drive_queue.size();
  assign errors_o  = errors;

  function automatic logic signed [31:0] sat32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // a*b/d, truncated toward zero and saturated
  function automatic longint scaled(longint a, logic [63:0] b, logic [63:0] d);
    logic [63:0] cap, m, q, r, mag;
    logic        neg;
    cap = 64'h8000_0000;
    neg = a < 0;
    m   = neg ? 64'd0 - 64'(a) : 64'(a);
    q   = b / d;
    r   = b % d;
    if (q != 0 && m > cap / q) begin
      mag = cap;
    end else begin
      mag = m * q + (m * r) / d;
      if (mag > cap) mag = cap;
    end
    if (neg) return (mag >= cap) ? -64'sd2147483648 : -longint'(mag);
    return (mag >= cap) ? 64'sd2147483647 : longint'(mag);
  endfunction

  function automatic out_item_t next_drive(in_item_t it);
    out_item_t   res;
    longint      m, sp, e, e1, e2, o, iterm, dterm, inner, p, integ;
    logic        cool, stdf, parf, win, lim;
    logic signed [31:0] err;
    m    = longint'(it.measurement);
    sp   = longint'(it.target);
    cool = mode_q inside {MODE_COOL_STD, MODE_COOL_PAR, MODE_COOL_MAN};
    stdf = mode_q == MODE_HEAT_STD || mode_q == MODE_COOL_STD;
    parf = mode_q == MODE_HEAT_PAR || mode_q == MODE_COOL_PAR;
    err  = cool ? sat32(m - sp) : sat32(sp - m);
    e    = longint'(err);
    e1   = longint'(e1_q);
    e2   = longint'(e2_q);
    lim  = 1'b0;
    if (!stdf && !parf) begin
      isum_q = '0;
      e1_q   = '0;
      res.drive     = held_q;
      res.in_window = 1'b0;
      res.at_limit  = 1'b0;
      return res;
    end
    win = 100 * m < (100 + WINDOW_PERCENT) * sp && 100 * m > (100 - WINDOW_PERCENT) * sp;
    if (stdf) begin
      if (win) begin
        iterm = (ki_q != 0) ? scaled(e + e1, 64'(LOOP_TIME_Q16), 64'(ki_q) * 2) : 0;
        dterm = scaled(e - 2 * e1 + e2, 64'(kd_q), 64'(LOOP_TIME_Q16));
        inner = (e - e1) + iterm + dterm;
        o = longint'(held_q) + scaled(inner, 64'(kp_q), 64'd65536);
      end else begin
        o = scaled(e, 64'(kp_q), 64'd65536);
      end
    end else begin
      p     = scaled(e, 64'(kp_q), 64'd65536);
      integ = 0;
      dterm = 0;
      if (win) begin
        integ = longint'(isum_q)
              + scaled(e + e1, 64'(ki_q) * 64'(LOOP_TIME_Q16), 64'd131072);
        dterm = scaled(e - e1, 64'(kd_q), 64'd65536);
      end
      if (integ > longint'(imax_q)) integ = longint'(imax_q);
      else if (integ < longint'(imin_q)) integ = longint'(imin_q);
      isum_q = integ[31:0];
      o = p + integ + dterm;
    end
    if (o > longint'(dmax_q)) begin
      o = longint'(dmax_q);
      lim = 1'b1;
    end else if (o < longint'(dmin_q)) begin
      o = longint'(dmin_q);
      lim = 1'b1;
    end
    held_q = o[31:0];
    e2_q   = e1_q;
    e1_q   = err;
    res.drive     = held_q;
    res.in_window = win;
    res.at_limit  = lim;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      mode_q = ModeRst;
      kp_q   = KpRst;
      ki_q   = '0;
      kd_q   = '0;
      imax_q = LimitRst;
      imin_q = '0;
      dmax_q = LimitRst;
      dmin_q = '0;
      held_q = '0;
      isum_q = '0;
      e1_q   = '0;
      e2_q   = '0;
      drive_queue.delete();
      errors = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MODE:      mode_q = cfg_data_i[ModeW-1:0];
          CFG_KP:        kp_q   = cfg_data_i[GainW-1:0];
          CFG_KI:        ki_q   = cfg_data_i[GainW-1:0];
          CFG_KD:        kd_q   = cfg_data_i[GainW-1:0];
          CFG_INT_MAX:   imax_q = cfg_data_i;
          CFG_INT_MIN:   imin_q = cfg_data_i;
          CFG_DRIVE_MAX: dmax_q = cfg_data_i;
          CFG_DRIVE_MIN: dmin_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) drive_queue.push_back(next_drive(in_item_i));
      if (out_valid_i && out_ready_i) begin
        if (drive_queue.size() == 0) begin
          $display("%0t: unexpected item drive=%0d win=%0b lim=%0b", $time,
                   out_item_i.drive, out_item_i.in_window, out_item_i.at_limit);
          errors++;
        end else begin
          want = drive_queue.pop_front();
          if (out_item_i.drive !== want.drive) begin
            $display("%0t: drive expected %0d actual %0d", $time, want.drive, out_item_i.drive);
            errors++;
          end
          if (out_item_i.in_window !== want.in_window) begin
            $display("%0t: in_window expected %0b actual %0b", $time, want.in_window,
                     out_item_i.in_window);
            errors++;
          end
          if (out_item_i.at_limit !== want.at_limit) begin
            $display("%0t: at_limit expected %0b actual %0b", $time, want.at_limit,
                     out_item_i.at_limit);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the PID controller testbench: clock, reset, register writes, samples and verdict.
// Depends on pidc_pkg, pid_controller_dual_form and pidc_checker.
`timescale 1ns / 1ps

module testbench;
  import pidc_pkg::*;

  localparam int StallLimit = 5000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DataW-1:0]   cfg_data_i = '0;
  int                 pending, errors;
  int                 send_idle = 0, recv_idle = 0;
  bit                 hold_req = 0;
  int                 quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  pid_controller_dual_form DUT (.*);

  pidc_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_item_i(out_item_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  // result side, with one long hold-off on request
  always @(posedge clk_i) begin
    int hold;
    if (hold_req && hold == 0) hold = 400;
    if (hold > 0) begin
      hold--;
      out_ready_i <= 1'b0;
      if (hold == 0) hold_req = 0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [DataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(logic signed [31:0] meas, logic signed [31:0] tgt);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{measurement: meas, target: tgt};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // sender stops until every result is back, then the block is left to settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_gain();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'h7fff_ffff;
      2: return 32'd65536;
      3: return $urandom_range(32'h4_0000);
      4: return $urandom_range(32'h1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic pick_limits(cfg_idx_e hi_idx, cfg_idx_e lo_idx);
    logic signed [31:0] a, b;
    case ($urandom_range(4))
      0: begin a = 32'sh7fff_ffff; b = 32'sh8000_0000; end
      1: begin a = 32'sd6553600; b = 32'sd0; end
      2: begin a = $urandom; b = $urandom; end
      default: begin
        a = $urandom_range(32'h100_0000);
        b = -$signed(32'($urandom_range(32'h100_0000)));
      end
    endcase
    write_reg(hi_idx, a);
    write_reg(lo_idx, b);
  endtask

  task automatic random_sample();
    logic signed [31:0] tgt, meas, span;
    case ($urandom_range(9))
      0, 1: begin
        tgt  = $urandom;
        meas = $urandom;
      end
      2: begin
        tgt  = -$signed(32'($urandom_range(32'h100_0000)));
        meas = tgt + $signed(32'($urandom_range(200))) - 100;
      end
      default: begin
        // near the setpoint, mostly inside the window
        tgt  = $urandom_range(32'h100_0000, 1);
        span = tgt / 80 + 1;
        meas = tgt + $signed(32'($urandom_range(2 * span))) - span;
      end
    endcase
    send_sample(meas, tgt);
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: manual at reset, then each form with extreme values
    send_sample(32'sd100, 32'sd200);
    drain();
    write_reg(CFG_KI, 32'd65536);
    write_reg(CFG_KD, 32'd65536);
    write_reg(CFG_MODE, MODE_HEAT_STD);
    send_sample(32'sh8000_0000, 32'sh7fff_ffff);
    send_sample(32'sh7fff_ffff, 32'sh8000_0000);
    send_sample(32'sd6553600, 32'sd6553600 + 32'sd1000);
    send_sample(32'sd6553600, 32'sd6553600 - 32'sd1000);
    send_sample(32'sd0, 32'sd0);
    send_sample(-32'sd100, -32'sd100);
    drain();
    write_reg(CFG_MODE, MODE_HEAT_PAR);
    write_reg(CFG_KP, 32'h7fff_ffff);
    send_sample(32'sd6553600, 32'sd6553700);
    send_sample(32'sd6553700, 32'sd6553600);
    send_sample(32'sh8000_0000, 32'sh7fff_ffff);
    drain();
    write_reg(CFG_MODE, MODE_COOL_STD);
    write_reg(CFG_KI, 32'd0);
    send_sample(32'sd655360, 32'sd650000);
    send_sample(32'sd650000, 32'sd655360);
    drain();
    write_reg(CFG_MODE, MODE_COOL_PAR);
    send_sample(32'sd655360, 32'sd656000);
    drain();
    write_reg(CFG_MODE, MODE_COOL_MAN);
    send_sample(32'sd1, 32'sd2);
    drain();
    write_reg(CFG_MODE, 3'd6);
    send_sample(32'sd5, 32'sd2);
    drain();

    for (phase = 0; phase < 16; phase++) begin
      write_reg(CFG_MODE, (phase % 8 < 6) ? ((phase % 3 == 2) ? (phase % 6) : phase % 6)
                                          : phase % 8);
      write_reg(CFG_KP, pick_gain());
      write_reg(CFG_KI, pick_gain());
      write_reg(CFG_KD, pick_gain());
      pick_limits(CFG_INT_MAX, CFG_INT_MIN);
      pick_limits(CFG_DRIVE_MAX, CFG_DRIVE_MIN);
      if (phase < 5) begin
        send_idle = 34;
        recv_idle = 80;
      end else if (phase < 10) begin
        send_idle = 80;
        recv_idle = 34;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (phase == 11) hold_req = 1;
      repeat (125) random_sample();
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
